// ----- rtl/core/pfx_pkg.sv -----
`default_nettype none
package pfx_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int STEP_W      = $clog2(VALUE_WIDTH + 1);
	localparam int SYM_W       = 8;
	localparam int ERR_W       = 3;

	localparam logic [SYM_W-1:0] SYM_ZERO    = 8'd48;
	localparam logic [SYM_W-1:0] DIGIT_COUNT = 8'd10;
	localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_TIMES   = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_DIVIDE  = 8'h2F;

	localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
	localparam logic [ERR_W-1:0] ERR_DIV0   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_UNDER  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_OVER   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_SYMBOL = 3'd4;
	localparam logic [ERR_W-1:0] ERR_COUNT  = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [VALUE_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/pfx_in_if.sv -----
`default_nettype none
interface pfx_in_if import pfx_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             is_end;

	modport source (output valid, output symbol, output is_end, input ready);
	modport sink (input valid, input symbol, input is_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pfx_out_if.sv -----
`default_nettype none
interface pfx_out_if import pfx_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic [ERR_W-1:0]              error;

	modport source (output valid, output value, output error, input ready);
	modport sink (input valid, input value, input error, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pfx_divider.sv -----
`default_nettype none
module pfx_divider import pfx_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                    busy_q;
	logic                    done_q;
	logic [STEP_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0]  quo_q;
	logic [VALUE_WIDTH-1:0]  rem_q;
	logic [VALUE_WIDTH-1:0]  dvs_q;
	logic                    neg_q;
	logic [VALUE_WIDTH-1:0]  mag_a;
	logic [VALUE_WIDTH-1:0]  mag_b;
	logic [VALUE_WIDTH+1:0]  diff;

	assign mag_a = req.dividend[VALUE_WIDTH-1] ? -req.dividend : req.dividend;
	assign mag_b = req.divisor[VALUE_WIDTH-1] ? -req.divisor : req.divisor;
	assign diff  = {1'b0, rem_q, quo_q[VALUE_WIDTH-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= req.dividend[VALUE_WIDTH-1] ^ req.divisor[VALUE_WIDTH-1];
		end else if (busy_q) begin
			if (diff[VALUE_WIDTH+1]) begin
				rem_q <= {rem_q[VALUE_WIDTH-2:0], quo_q[VALUE_WIDTH-1]};
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
			end else begin
				rem_q <= diff[VALUE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -quo_q : quo_q;

endmodule
`default_nettype wire

// ----- rtl/core/postfix_expression_evaluator_top.sv -----
// a digit is taken in the idle state; + - * pass through a stack read state, / also through a divide state
// wait states come from the registered stack memory read and the bit-serial divider
// an end transaction shows its result on the output in the cycle after acceptance
// a new transaction is accepted only in the idle state and while the output is not stalled
// reset clears state, stack count, sticky error and output valid; stack memory is not cleared
`default_nettype none
module postfix_expression_evaluator_top import pfx_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	pfx_in_if.sink   in_ch,
	pfx_out_if.source out_ch
);

	state_t                  state_q;
	state_t                  state_d;
	logic [CNT_W-1:0]        count_q;
	logic [ERR_W-1:0]        err_q;
	logic [VALUE_WIDTH-1:0]  top_q;
	logic [VALUE_WIDTH-1:0]  rdata_q;
	logic [SYM_W-1:0]        op_q;
	logic                    out_valid_q;
	logic [VALUE_WIDTH-1:0]  out_value_q;
	logic [ERR_W-1:0]        out_error_q;
	logic [VALUE_WIDTH-1:0]  mem [STACK_DEPTH];

	logic                    accept;
	logic                    is_digit;
	logic                    is_op;
	logic                    op_go;
	logic [CNT_W-1:0]        cnt_m1;
	logic [CNT_W-1:0]        cnt_m2;
	logic                    mem_we;
	logic                    mem_re;
	logic [ERR_W-1:0]        new_err;
	logic [VALUE_WIDTH-1:0]  mul_res;
	logic [VALUE_WIDTH-1:0]  alu_res;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	assign accept   = in_ch.valid && in_ch.ready;
	assign is_digit = (in_ch.symbol >= SYM_ZERO) && (in_ch.symbol < SYM_ZERO + DIGIT_COUNT);
	assign is_op    = (in_ch.symbol == SYM_PLUS) || (in_ch.symbol == SYM_MINUS)
	               || (in_ch.symbol == SYM_TIMES) || (in_ch.symbol == SYM_DIVIDE);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign cnt_m2   = count_q - CNT_W'(2);
	assign mul_res  = rdata_q * top_q;

	// error raised by a symbol transaction
	always_comb begin
		priority if (is_digit) begin
			new_err = (count_q == CNT_W'(STACK_DEPTH)) ? ERR_OVER : ERR_NONE;
		end else if (!is_op) begin
			new_err = ERR_SYMBOL;
		end else if (count_q < CNT_W'(2)) begin
			new_err = ERR_UNDER;
		end else if (in_ch.symbol == SYM_DIVIDE && top_q == '0) begin
			new_err = ERR_DIV0;
		end else begin
			new_err = ERR_NONE;
		end
	end

	always_comb begin
		unique case (op_q)
			SYM_PLUS:  alu_res = rdata_q + top_q;
			SYM_MINUS: alu_res = rdata_q - top_q;
			default:   alu_res = mul_res;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (op_go) state_d = ST_READ;
			ST_READ: if (op_q == SYM_DIVIDE) state_d = ST_DIV;
			         else state_d = ST_IDLE;
			ST_DIV:  if (div_rsp.done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the control
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
		op_go  = accept && !in_ch.is_end && err_q == ERR_NONE && is_op && new_err == ERR_NONE;
		mem_we = accept && !in_ch.is_end && err_q == ERR_NONE && is_digit
		      && new_err == ERR_NONE && count_q != '0;
		mem_re = op_go;
		div_req.start    = (state_q == ST_READ) && (op_q == SYM_DIVIDE);
		div_req.dividend = rdata_q;
		div_req.divisor  = top_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_m1[IDX_W-1:0]] <= top_q;
		end
		if (mem_re) begin
			rdata_q <= mem[cnt_m2[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && in_ch.is_end) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				err_q       <= ERR_NONE;
			end else if (accept && err_q == ERR_NONE) begin
				err_q <= new_err;
				if (is_digit && new_err == ERR_NONE) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if ((state_q == ST_READ && op_q != SYM_DIVIDE)
			             || (state_q == ST_DIV && div_rsp.done)) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch.is_end) begin
			priority if (err_q != ERR_NONE) begin
				out_value_q <= '0;
				out_error_q <= err_q;
			end else if (count_q != CNT_W'(1)) begin
				out_value_q <= '0;
				out_error_q <= ERR_COUNT;
			end else begin
				out_value_q <= top_q;
				out_error_q <= ERR_NONE;
			end
		end
		if (mem_re) begin
			op_q <= in_ch.symbol;
		end
		if (accept && !in_ch.is_end && err_q == ERR_NONE && is_digit && new_err == ERR_NONE) begin
			top_q <= VALUE_WIDTH'(in_ch.symbol - SYM_ZERO);
		end else if (state_q == ST_READ && op_q != SYM_DIVIDE) begin
			top_q <= alu_res;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			top_q <= div_rsp.quotient;
		end
	end

	pfx_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_ch.valid = out_valid_q;
	assign out_ch.value = out_value_q;
	assign out_ch.error = out_error_q;

endmodule
`default_nettype wire

// ----- rtl/core/pfx_checker.sv -----
`default_nettype none
module pfx_checker import pfx_pkg::*; (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_ready,
	input wire                   in_is_end,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire [VALUE_WIDTH-1:0] out_value,
	input wire [ERR_W-1:0]       out_error
);

	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error != ERR_NONE |-> out_value == '0)
		else $error("value not zero on error");

	a_result_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_is_end))
		else $error("result without end transaction");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_is_end |=> out_valid)
		else $error("end transaction gave no result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_error))
		else $error("stalled result changed");

endmodule

bind postfix_expression_evaluator_top pfx_checker u_pfx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_is_end (in_ch.is_end),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.value),
	.out_error (out_ch.error)
);
`default_nettype wire
